### rtl/cpeq_pkg.sv
package cpeq_pkg;

   localparam int TYPE_BITS = 5;
   localparam int FILL_BITS = 5;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DROPPED  = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]           command;
      logic [TYPE_BITS-1:0] event_type;
      logic [31:0]          event_payload;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [TYPE_BITS-1:0] popped_type;
      logic [31:0]          popped_payload;
      logic [FILL_BITS-1:0] fill_level;
      logic                 resync_needed;
      logic [31:0]          dropped_telemetry_total;
      logic [31:0]          evicted_telemetry_total;
      logic [31:0]          overflow_total;
   } rsp_type;

   // completion report from the sequencer to the top level
   typedef struct packed {
      logic                 valid;
      logic [1:0]           status;
      logic                 evicted;
      logic [TYPE_BITS-1:0] popped_type;
      logic [31:0]          popped_payload;
      logic [FILL_BITS-1:0] fill_level;
   } done_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_FIND,
      ST_SHIFT,
      ST_APPEND
   } seq_state_type;

endpackage

### rtl/cpeq_seq.sv
module cpeq_seq #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cpeq_pkg::req_type item,
   input  logic [31:0]       type_mask,
   output cpeq_pkg::done_type done
);
   import cpeq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH + 2);
   localparam int EW = TYPE_BITS + PAYLOAD_BITS;

   logic [EW-1:0] mem [QUEUE_DEPTH];

   seq_state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [EW-1:0] rd_ff;

   logic          we;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic [AW-1:0] raddr;

   logic [63:0]          in_wide;
   logic [63:0]          rd_wide;
   logic [31:0]          cnt_wide;
   logic [EW-1:0]        new_entry;
   logic [TYPE_BITS-1:0] rd_type;
   logic [IW-1:0]        last_idx;
   logic                 full;

   // logical position to memory address, one conditional subtract
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [IW-1:0] i);
      logic [IW:0] s;
      begin
         s = (IW + 1)'(h) + (IW + 1)'(i);
         if (s >= (IW + 1)'(QUEUE_DEPTH)) s = s - (IW + 1)'(QUEUE_DEPTH);
         return s[AW-1:0];
      end
   endfunction

   assign in_wide   = 64'(item.event_payload);
   assign new_entry = {item.event_type, in_wide[PAYLOAD_BITS-1:0]};
   assign rd_type   = rd_ff[EW-1 -: TYPE_BITS];
   assign rd_wide   = 64'(rd_ff[PAYLOAD_BITS-1:0]);
   assign last_idx  = IW'(count_ff) - IW'(1);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign cnt_wide  = 32'(count_in);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      we       = 1'b0;
      waddr    = phys(head_ff, IW'(count_ff));
      wdata    = new_entry;
      raddr    = phys(head_ff, idx_ff + IW'(1));
      done     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (item.command)
                  CMD_PUSH: begin
                     if (!full) begin
                        we       = 1'b1;
                        count_in = count_ff + CW'(1);
                        done.valid = 1'b1;
                     end else if (type_mask[item.event_type]) begin
                        done.valid  = 1'b1;
                        done.status = STAT_DROPPED;
                     end else begin
                        raddr    = head_ff;
                        idx_in   = '0;
                        state_in = ST_FIND;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        done.valid  = 1'b1;
                        done.status = STAT_EMPTY;
                     end else begin
                        raddr    = head_ff;
                        state_in = ST_POP;
                     end
                  end
                  default: begin
                     done.valid = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            done.valid          = 1'b1;
            done.popped_type    = rd_type;
            done.popped_payload = rd_wide[31:0];
            count_in            = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_in = '0;
            end else if (head_ff == AW'(QUEUE_DEPTH - 1)) begin
               head_in = '0;
            end else begin
               head_in = head_ff + AW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_FIND: begin
            // read of the next position is issued while this one is checked
            if (type_mask[rd_type]) begin
               state_in = (idx_ff == last_idx) ? ST_APPEND : ST_SHIFT;
            end else if (idx_ff == last_idx) begin
               done.valid  = 1'b1;
               done.status = STAT_OVERFLOW;
               state_in    = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_SHIFT: begin
            // rd_ff holds position idx+1, moved one place toward the head
            we     = 1'b1;
            waddr  = phys(head_ff, idx_ff);
            wdata  = rd_ff;
            raddr  = phys(head_ff, idx_ff + IW'(2));
            idx_in = idx_ff + IW'(1);
            if (idx_ff + IW'(1) == last_idx) state_in = ST_APPEND;
         end
         ST_APPEND: begin
            we           = 1'b1;
            waddr        = phys(head_ff, last_idx);
            done.valid   = 1'b1;
            done.evicted = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      done.fill_level = cnt_wide[FILL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("held count above depth");

   a_evict_full : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND || state_ff == ST_SHIFT || state_ff == ST_APPEND)
      |-> full)
      else $error("eviction running on a queue that is not full");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done.valid |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after completion");

   a_evict_count : assert property (@(posedge clock) disable iff (reset)
      done.evicted |=> count_ff == $past(count_ff))
      else $error("eviction changed the held count");

endmodule

### rtl/class_priority_event_queue_core.sv
// Event queue with telemetry/control classes.
// req channel: req_valid/req_stall with req_item (command, event_type, event_payload).
//   An item is taken when req_valid is high and req_stall low. One item is
//   worked on at a time; req_stall is high from acceptance until its result
//   is in the output register.
// rsp channel: rsp_valid/rsp_stall with rsp_item, exactly one result per item.
//   The output register lets a new item be taken while a result waits; the
//   next item starts work once that result is taken.
// csr channel: csr_valid/csr_ready/csr_data writes the telemetry type mask.
//   It is always ready; write it only while no item is in flight.
// Clear, drop, empty pop and push with space finish in the sequencer's idle
//   state; a pop reads the head entry first; a control push into a full queue
//   scans and shifts the stored entries one entry per cycle. The next item is
//   taken only after a result is registered.
// Reset: queue empty, head at 0, counters and resync flag cleared, mask 3.
//   The entry memory is not cleared; only data read from held entries is used.
// A stalled receiver holds rsp_item steady and blocks the next item's start.
module class_priority_event_queue_core #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpeq_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpeq_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import cpeq_pkg::*;

   req_type     item_ff;
   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] mask_ff;
   logic [31:0] drop_ff, drop_in;
   logic [31:0] evict_ff, evict_in;
   logic [31:0] ovf_ff, ovf_in;
   logic        resync_ff, resync_in;
   logic        start;
   logic        req_take;
   done_type    done;

   assign req_stall = busy_ff;
   assign req_take  = req_valid & ~busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   // the output register is free at the edge where work begins
   assign start     = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   cpeq_seq #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item_ff),
      .type_mask (mask_ff),
      .done      (done)
   );

   always_comb begin
      drop_in      = drop_ff;
      evict_in     = evict_ff;
      ovf_in       = ovf_ff;
      resync_in    = resync_ff;
      busy_in      = busy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (done.valid) begin
         if (done.status == STAT_DROPPED) drop_in = drop_ff + 32'd1;
         if (done.evicted) evict_in = evict_ff + 32'd1;
         if (done.status == STAT_OVERFLOW) begin
            ovf_in    = ovf_ff + 32'd1;
            resync_in = 1'b1;
         end
         if (item_ff.command == CMD_CLEAR) resync_in = 1'b0;
         rsp_in.status                  = done.status;
         rsp_in.popped_type             = done.popped_type;
         rsp_in.popped_payload          = done.popped_payload;
         rsp_in.fill_level              = done.fill_level;
         rsp_in.resync_needed           = resync_in;
         rsp_in.dropped_telemetry_total = drop_in;
         rsp_in.evicted_telemetry_total = evict_in;
         rsp_in.overflow_total          = ovf_in;
         rsp_valid_in                   = 1'b1;
         busy_in                        = 1'b0;
      end
      if (req_take) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= 32'd3;
         drop_ff      <= '0;
         evict_ff     <= '0;
         ovf_ff       <= '0;
         resync_ff    <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         drop_ff      <= drop_in;
         evict_ff     <= evict_in;
         ovf_ff       <= ovf_in;
         resync_ff    <= resync_in;
         if (csr_valid && csr_ready) mask_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) item_ff <= req_item;
      rsp_ff <= rsp_in;
   end

endmodule
